// File: rtl/fcr_pkg.sv
package fcr_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int LINE_COUNT = 4;
    localparam int LINE_IDX_W = $clog2(LINE_COUNT);
    localparam int SUM_W      = SAMPLE_W + LINE_IDX_W;

    localparam int unsigned LINE_LEN [LINE_COUNT] = '{1024, 1152, 1280, 1408};

    localparam int MUL_A_W   = SAMPLE_W + 1;
    localparam int MUL_B_W   = GAIN_W;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);
    localparam int ACC_W     = MUL_P_W + 1;
    localparam int RND_W     = ACC_W - 15;

    localparam logic [GAIN_W-1:0] GAIN_ONE      = 16'd32768;
    localparam logic [GAIN_W-1:0] ROOM_SIZE_RST = 16'd16384;
    localparam logic [GAIN_W-1:0] DAMPING_RST   = 16'd16384;
    localparam logic [GAIN_W-1:0] WET_LEVEL_RST = 16'd9830;
    localparam logic [GAIN_W-1:0] DRY_LEVEL_RST = 16'd22938;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROOM_SIZE = 2'd0,
        REG_DAMPING   = 2'd1,
        REG_WET_LEVEL = 2'd2,
        REG_DRY_LEVEL = 2'd3
    } cfg_reg_t;

    function automatic int addr_width(input int unsigned len);
        return (len > 1) ? $clog2(len) : 1;
    endfunction

    function automatic logic [GAIN_W-1:0] gain_of(input logic [GAIN_W-1:0] v);
        return (v > GAIN_ONE) ? GAIN_ONE : v;
    endfunction

    function automatic logic signed [MUL_A_W-1:0] sext_a(input logic signed [SAMPLE_W-1:0] v);
        return {v[SAMPLE_W-1], v};
    endfunction

    function automatic logic signed [ACC_W-1:0] sext_p(input logic signed [MUL_P_W-1:0] v);
        return {v[MUL_P_W-1], v};
    endfunction

    // round half up, then arithmetic shift by 15
    function automatic logic signed [RND_W-1:0] round_q15(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + ACC_W'(16384);
        return t[ACC_W-1:15];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [RND_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > RND_W'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -RND_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/fcr_ram.sv
module fcr_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/fcr_serial_mul.sv
module fcr_serial_mul (
    input  logic                                  clk,
    input  logic                                  rstn,
    input  logic                                  start,
    input  logic signed [fcr_pkg::MUL_A_W-1:0]    a,
    input  logic        [fcr_pkg::MUL_B_W-1:0]    b,
    output logic                                  done,
    output logic signed [fcr_pkg::MUL_P_W-1:0]    product
);
    import fcr_pkg::*;

    logic                        running_reg, running_next;
    logic                        done_reg, done_next;
    logic [MUL_CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [MUL_A_W-1:0]   a_reg, a_next;
    logic [MUL_B_W-1:0]          b_reg, b_next;
    logic signed [MUL_A_W:0]     hi_reg, hi_next;
    logic [MUL_B_W-1:0]          lo_reg, lo_next;
    logic signed [MUL_A_W:0]     addend;
    logic signed [MUL_A_W:0]     psum;

    // one multiplier bit per cycle, partial product shifts out through lo
    assign addend = b_reg[0] ? {a_reg[MUL_A_W-1], a_reg} : '0;
    assign psum   = hi_reg + addend;

    always_comb begin
        running_next = running_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        if (start) begin
            running_next = 1'b1;
            cnt_next     = '0;
            a_next       = a;
            b_next       = b;
            hi_next      = '0;
            lo_next      = '0;
        end else if (running_reg) begin
            hi_next  = {psum[MUL_A_W], psum[MUL_A_W:1]};
            lo_next  = {psum[0], lo_reg[MUL_B_W-1:1]};
            b_next   = {1'b0, b_reg[MUL_B_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_B_W - 1)) begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg[MUL_A_W-1:0], lo_reg};

endmodule

// File: rtl/four_comb_feedback_reverb.sv
// Four-line feedback comb reverb on signed Q1.15 samples. One sample is taken per transfer and
// gives one mixed sample; a new sample is taken only after the previous one is worked through
// in seven 16-step passes through one shared bit-serial multiplier (feedback gain, four line
// products, dry and wet gains). A finished result waits in the output register while the next
// sample is already taken. Delay lines come out of reset silent without a clearing pass. Gains
// are written through the cfg port (room_size, damping, wet_level, dry_level); values above
// 32768 act as 1.0. Write them only while the block is idle.
module four_comb_feedback_reverb (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [fcr_pkg::SAMPLE_W-1:0]   s_sample_in,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [fcr_pkg::SAMPLE_W-1:0]   m_sample_out,
    output logic                                  m_active,
    input  logic                                  cfg_we,
    input  logic [fcr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fcr_pkg::GAIN_W-1:0]            cfg_data
);
    import fcr_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_FB   = 6'b000010,
        ST_LINE = 6'b000100,
        ST_DRY  = 6'b001000,
        ST_WET  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t                      state_reg, state_next;
    logic [GAIN_W-1:0]           room_reg, damp_reg, wet_reg, dry_reg;
    logic signed [SAMPLE_W-1:0]  x_reg, x_next;
    logic [GAIN_W-1:0]           fb_reg, fb_next;
    logic [LINE_IDX_W-1:0]       idx_reg, idx_next, idx_inc;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic                        mul_start_reg, mul_start_next;
    logic signed [MUL_A_W-1:0]   mul_a_reg, mul_a_next;
    logic [MUL_B_W-1:0]          mul_b_reg, mul_b_next;
    logic                        m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0]  out_sample_reg, out_sample_next;
    logic                        out_active_reg, out_active_next;

    logic                        s_transfer;
    logic                        mul_done;
    logic signed [MUL_P_W-1:0]   mul_p;
    logic signed [ACC_W-1:0]     mul_p_ext;
    logic signed [RND_W-1:0]     fb_full;
    logic signed [RND_W-1:0]     line_val;
    logic                        line_wr;
    logic signed [SAMPLE_W-1:0]  line_wdata;
    logic signed [SUM_W-1:0]     qsum;
    logic signed [SAMPLE_W-1:0]  quarter;
    logic signed [SAMPLE_W-1:0]  old_line [LINE_COUNT];

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            room_reg <= ROOM_SIZE_RST;
            damp_reg <= DAMPING_RST;
            wet_reg  <= WET_LEVEL_RST;
            dry_reg  <= DRY_LEVEL_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROOM_SIZE: room_reg <= cfg_data;
                REG_DAMPING:   damp_reg <= cfg_data;
                REG_WET_LEVEL: wet_reg  <= cfg_data;
                REG_DRY_LEVEL: dry_reg  <= cfg_data;
            endcase
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_transfer = s_valid && s_ready;

    // delay lines; an entry reads as silence until its line has wrapped once
    for (genvar g = 0; g < LINE_COUNT; g++) begin : g_line
        localparam int PW = addr_width(LINE_LEN[g]);

        logic [PW-1:0]       pos_reg, pos_next;
        logic                wrapped_reg, wrapped_next;
        logic                we;
        logic [SAMPLE_W-1:0] rd_data;

        assign we = line_wr && (idx_reg == LINE_IDX_W'(g));

        always_comb begin
            pos_next     = pos_reg;
            wrapped_next = wrapped_reg;
            if (we) begin
                if (pos_reg == PW'(LINE_LEN[g] - 1)) begin
                    pos_next     = '0;
                    wrapped_next = 1'b1;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pos_reg     <= '0;
                wrapped_reg <= 1'b0;
            end else begin
                pos_reg     <= pos_next;
                wrapped_reg <= wrapped_next;
            end
        end

        fcr_ram #(
            .DEPTH(LINE_LEN[g]),
            .WIDTH(SAMPLE_W)
        ) u_ram (
            .clk  (aclk),
            .we   (we),
            .waddr(pos_reg),
            .wdata(line_wdata),
            .re   (s_transfer),
            .raddr(pos_reg),
            .rdata(rd_data)
        );

        assign old_line[g] = wrapped_reg ? signed'(rd_data) : '0;
    end

    fcr_serial_mul u_mul (
        .clk    (aclk),
        .rstn   (aresetn),
        .start  (mul_start_reg),
        .a      (mul_a_reg),
        .b      (mul_b_reg),
        .done   (mul_done),
        .product(mul_p)
    );

    assign mul_p_ext  = sext_p(mul_p);
    assign fb_full    = round_q15(mul_p_ext);
    assign line_val   = fb_full + RND_W'(x_reg);
    assign line_wdata = sat16(line_val);
    assign qsum       = sum_reg + SUM_W'(2);
    assign quarter    = qsum[SUM_W-1:LINE_IDX_W];
    assign idx_inc    = idx_reg + 1'b1;

    always_comb begin
        state_next      = state_reg;
        x_next          = x_reg;
        fb_next         = fb_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        acc_next        = acc_reg;
        mul_start_next  = 1'b0;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        line_wr         = 1'b0;
        m_valid_next    = m_valid_reg && !m_ready;
        out_sample_next = out_sample_reg;
        out_active_next = out_active_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_transfer) begin
                    x_next         = s_sample_in;
                    sum_next       = '0;
                    mul_a_next     = {1'b0, gain_of(room_reg)};
                    mul_b_next     = gain_of(damp_reg);
                    mul_start_next = 1'b1;
                    state_next     = ST_FB;
                end
            end
            ST_FB: begin
                if (mul_done) begin
                    fb_next        = fb_full[GAIN_W-1:0];
                    idx_next       = '0;
                    mul_a_next     = sext_a(old_line[0]);
                    mul_b_next     = fb_full[GAIN_W-1:0];
                    mul_start_next = 1'b1;
                    state_next     = ST_LINE;
                end
            end
            ST_LINE: begin
                if (mul_done) begin
                    line_wr        = 1'b1;
                    sum_next       = sum_reg + SUM_W'(old_line[idx_reg]);
                    mul_start_next = 1'b1;
                    if (idx_reg == LINE_IDX_W'(LINE_COUNT - 1)) begin
                        mul_a_next = sext_a(x_reg);
                        mul_b_next = gain_of(dry_reg);
                        state_next = ST_DRY;
                    end else begin
                        idx_next   = idx_inc;
                        mul_a_next = sext_a(old_line[idx_inc]);
                        mul_b_next = fb_reg;
                    end
                end
            end
            ST_DRY: begin
                if (mul_done) begin
                    acc_next       = mul_p_ext;
                    mul_a_next     = sext_a(quarter);
                    mul_b_next     = gain_of(wet_reg);
                    mul_start_next = 1'b1;
                    state_next     = ST_WET;
                end
            end
            ST_WET: begin
                if (mul_done) begin
                    acc_next   = acc_reg + mul_p_ext;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_sample_next = sat16(round_q15(acc_reg));
                    out_active_next = (wet_reg != '0);
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mul_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            idx_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            mul_start_reg <= mul_start_next;
            m_valid_reg   <= m_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg          <= x_next;
        fb_reg         <= fb_next;
        sum_reg        <= sum_next;
        acc_reg        <= acc_next;
        mul_a_reg      <= mul_a_next;
        mul_b_reg      <= mul_b_next;
        out_sample_reg <= out_sample_next;
        out_active_reg <= out_active_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_sample_reg;
    assign m_active     = out_active_reg;

endmodule
